FILE: rtl/hjg_pkg.sv
// ----------------------------------------------------------------------------
// hjg_pkg - shared types and constants of the heading jump gate
// Fixed-point constants, register indexes, sequencer states and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package hjg_pkg;

	// CORDIC iteration count and table
	localparam int ATAN_ITERATIONS = 16;
	localparam int ATAN_TAB_LEN    = 24;
	localparam int CORDIC_STEPS    = (ATAN_ITERATIONS < ATAN_TAB_LEN) ?
	                                 ATAN_ITERATIONS : ATAN_TAB_LEN;
	localparam int ITER_W          = $clog2(ATAN_TAB_LEN);

	// datapath widths
	localparam int DIFF_W = 33;   // position minus origin, mapped step
	localparam int MUL_W  = 49;   // 16 x 33 product
	localparam int ACC_W  = 50;   // sum of two products
	localparam int VEC_W  = 44;   // CORDIC x and y
	localparam int Z_W    = 36;   // CORDIC angle, 2^30 per radian

	// angles in Q2.13 and the CORDIC angle scale
	localparam logic signed [15:0]    PI_Q      = 16'sd25736;
	localparam logic signed [15:0]    HALF_PI_Q = 16'sd12868;
	localparam logic signed [16:0]    TWO_PI_Q  = 17'sd51472;
	localparam logic signed [Z_W-1:0] PI_Z      = 36'sd3373259426;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_OFFSET_X      = 3'd0,
		REG_OFFSET_Y      = 3'd1,
		REG_ROT_COS       = 3'd2,
		REG_ROT_SIN       = 3'd3,
		REG_LIMIT_TURNING = 3'd4,
		REG_LIMIT_STILL   = 3'd5,
		REG_MOTION_FLOOR  = 3'd6
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_PREP,
		ST_NORM,
		ST_CORDIC,
		ST_ROUND,
		ST_GATE
	} state_t;

	// truncated atan(2^-i), 2^30 per radian
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = 36'sh03243F6A8;
			5'd1:    v = 36'sh01DAC6705;
			5'd2:    v = 36'sh00FADBAFC;
			5'd3:    v = 36'sh007F56EA6;
			5'd4:    v = 36'sh003FEAB76;
			5'd5:    v = 36'sh001FFD55B;
			5'd6:    v = 36'sh000FFFAAA;
			5'd7:    v = 36'sh0007FFF55;
			5'd8:    v = 36'sh0003FFFEA;
			5'd9:    v = 36'sh0001FFFFD;
			5'd10:   v = 36'sh0000FFFFF;
			5'd11:   v = 36'sh00007FFFF;
			5'd12:   v = 36'sh00003FFFF;
			5'd13:   v = 36'sh00001FFFF;
			5'd14:   v = 36'sh00000FFFF;
			5'd15:   v = 36'sh000007FFF;
			5'd16:   v = 36'sh000003FFF;
			5'd17:   v = 36'sh000001FFF;
			5'd18:   v = 36'sh000000FFF;
			5'd19:   v = 36'sh0000007FF;
			5'd20:   v = 36'sh0000003FF;
			5'd21:   v = 36'sh0000001FF;
			5'd22:   v = 36'sh0000000FF;
			5'd23:   v = 36'sh00000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/heading_jump_gate_unit.sv
// ----------------------------------------------------------------------------
// heading_jump_gate_unit - map-frame transform and gated heading of motion
// Maps each odometry position into the map frame, takes the heading of the
// step from the last mapped point by CORDIC and rejects implausible jumps.
// ----------------------------------------------------------------------------
// One request is worked on at a time. After a request is accepted, one shared
// multiplier forms the four rotation products, a shift unit normalizes the
// step vector (eight bits or one bit a cycle), the shared CORDIC add/shift
// stage runs ATAN_ITERATIONS micro-rotations, and a rounding state and a gate
// state round the angle and apply the jump gate. A step that lies on an axis
// or is zero skips normalization and CORDIC. in_ready rises again in the same
// cycle as the result is offered. The result sits in an output register, so a
// new request is taken while the previous result waits; the block stalls in
// its gate state only if that register is still full. Configuration writes
// are always accepted and must be issued only while the block is idle.
module heading_jump_gate_unit
	import hjg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] turn_rate,
	input  logic signed [15:0] forward_speed,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] map_x,
	output logic signed [31:0] map_y,
	output logic signed [15:0] heading,
	output logic               heading_held
);

	// configuration registers
	logic signed [31:0] offset_x_q, offset_y_q;
	logic signed [15:0] rot_cos_q, rot_sin_q;
	logic [14:0]        limit_turning_q, limit_still_q, motion_floor_q;

	// state carried between requests
	logic signed [31:0] last_x_q, last_y_q;
	logic signed [15:0] last_heading_q;

	// sequencer
	state_t            state_q, state_d;
	logic [2:0]        mstep_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;

	// datapath registers
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [15:0]       rate_q, speed_q;
	logic signed [MUL_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       mx_q, my_q;
	logic signed [VEC_W-1:0]  x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [15:0]       h_q;
	logic signed [31:0]       out_x_q, out_y_q;
	logic signed [15:0]       out_heading_q;
	logic                     out_held_q;

	// round half up by 2^14 and saturate to 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] s;
		logic signed [31:0]      r;
		t = v + ACC_W'(8192);
		s = t >>> 14;
		if (s > ACC_W'(64'sd2147483647)) begin
			r = 32'sh7FFFFFFF;
		end else if (s < -ACC_W'(64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	// true when -2^k < v < 2^k
	function automatic logic below_mag(input logic signed [VEC_W-1:0] v, input int k);
		logic signed [VEC_W-1:0] lim;
		lim = VEC_W'(1) <<< k;
		return (v < lim) && (v > -lim);
	endfunction

	// shared multiplier operand select
	logic signed [15:0]       mul_a;
	logic signed [DIFF_W-1:0] mul_b;
	logic signed [MUL_W-1:0]  mul_p;
	logic signed [ACC_W-1:0]  sum_x, sum_y;

	always_comb begin
		mul_a = (mstep_q == 3'd0 || mstep_q == 3'd3) ? rot_cos_q : rot_sin_q;
		mul_b = (mstep_q == 3'd0 || mstep_q == 3'd2) ? dx_q : dy_q;
		mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
		sum_x = acc_q + ACC_W'(prod_q);
		sum_y = acc_q - ACC_W'(prod_q);
	end

	// step from the last mapped point and its special cases
	logic signed [DIFF_W-1:0] ex, ey;
	logic                     axis_case;

	always_comb begin
		ex = DIFF_W'(mx_q) - DIFF_W'(last_x_q);
		ey = DIFF_W'(my_q) - DIFF_W'(last_y_q);
		axis_case = (ey == '0) || (ex == '0);
	end

	// normalization decisions
	logic norm_by8, norm_by1;

	always_comb begin
		norm_by8 = below_mag(x_q, 31) && below_mag(y_q, 31);
		norm_by1 = below_mag(x_q, 39) && below_mag(y_q, 39);
	end

	// CORDIC micro-rotation
	logic signed [VEC_W-1:0] xs, ys;
	logic signed [Z_W-1:0]   z_add;

	always_comb begin
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		z_add = atan_entry(iter_q);
	end

	// angle rounding to Q2.13 with clamp into (-pi, pi]
	logic signed [Z_W-1:0] z_rnd;
	logic signed [18:0]    r_q13;
	logic signed [15:0]    h_rnd;

	always_comb begin
		z_rnd = (z_q + Z_W'(65536)) >>> 17;
		r_q13 = z_rnd[18:0];
		if (r_q13 > 19'(PI_Q) || r_q13 <= -19'(PI_Q)) begin
			h_rnd = PI_Q;
		end else begin
			h_rnd = r_q13[15:0];
		end
	end

	// jump gate
	logic signed [16:0] step_raw, step_w;
	logic [16:0]        step_mag, rate_mag, speed_mag;
	logic               held;

	always_comb begin
		step_raw = 17'(h_q) - 17'(last_heading_q);
		if (step_raw > 17'(PI_Q)) begin
			step_w = step_raw - TWO_PI_Q;
		end else if (step_raw <= -17'(PI_Q)) begin
			step_w = step_raw + TWO_PI_Q;
		end else begin
			step_w = step_raw;
		end
		step_mag  = step_w[16] ? 17'(-step_w) : 17'(step_w);
		rate_mag  = rate_q[15] ? 17'(-17'(rate_q)) : 17'(rate_q);
		speed_mag = speed_q[15] ? 17'(-17'(speed_q)) : 17'(speed_q);
		held = ((step_mag > 17'(limit_turning_q)) && (rate_mag > 17'(motion_floor_q))) ||
		       ((step_mag > 17'(limit_still_q)) && (speed_mag <= 17'(motion_floor_q)));
	end

	// output register free to load this cycle
	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MAP;
			ST_MAP:    if (mstep_q == 3'd4) state_d = ST_PREP;
			ST_PREP:   state_d = axis_case ? ST_GATE : ST_NORM;
			ST_NORM:   if (!norm_by1) state_d = ST_CORDIC;
			ST_CORDIC: if (iter_q == ITER_W'(CORDIC_STEPS - 1)) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_GATE;
			ST_GATE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
	end

	// sequencer, result valid, configuration and carried state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			mstep_q         <= '0;
			iter_q          <= '0;
			out_valid_q     <= 1'b0;
			offset_x_q      <= '0;
			offset_y_q      <= '0;
			rot_cos_q       <= 16'sd16384;
			rot_sin_q       <= '0;
			limit_turning_q <= 15'd1638;
			limit_still_q   <= 15'd4096;
			motion_floor_q  <= 15'd41;
			last_x_q        <= '0;
			last_y_q        <= '0;
			last_heading_q  <= '0;
		end else begin
			state_q <= state_d;

			// advance the product and iteration counters
			if (state_q == ST_MAP) begin
				mstep_q <= mstep_q + 3'd1;
			end else begin
				mstep_q <= '0;
			end
			if (state_q == ST_CORDIC) begin
				iter_q <= iter_q + ITER_W'(1);
			end else begin
				iter_q <= '0;
			end

			// hold the result until taken, load a new one at the gate
			if (state_q == ST_GATE && out_free) begin
				out_valid_q    <= 1'b1;
				last_x_q       <= mx_q;
				last_y_q       <= my_q;
				last_heading_q <= held ? last_heading_q : h_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// write configuration, drop unknown indexes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_OFFSET_X:      offset_x_q      <= cfg_data;
					REG_OFFSET_Y:      offset_y_q      <= cfg_data;
					REG_ROT_COS:       rot_cos_q       <= cfg_data[15:0];
					REG_ROT_SIN:       rot_sin_q       <= cfg_data[15:0];
					REG_LIMIT_TURNING: limit_turning_q <= cfg_data[14:0];
					REG_LIMIT_STILL:   limit_still_q   <= cfg_data[14:0];
					REG_MOTION_FLOOR:  motion_floor_q  <= cfg_data[14:0];
					default:           ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dx_q    <= DIFF_W'(pos_x) - DIFF_W'(offset_x_q);
					dy_q    <= DIFF_W'(pos_y) - DIFF_W'(offset_y_q);
					rate_q  <= turn_rate;
					speed_q <= forward_speed;
				end
			end
			ST_MAP: begin
				prod_q <= mul_p;
				case (mstep_q)
					3'd1:    acc_q <= ACC_W'(prod_q);
					3'd2:    mx_q  <= round_sat(sum_x);
					3'd3:    acc_q <= ACC_W'(prod_q);
					3'd4:    my_q  <= round_sat(sum_y);
					default: ;
				endcase
			end
			ST_PREP: begin
				// settle axis steps at once, else fold into the right half plane
				if (ey == '0) begin
					h_q <= ex[DIFF_W-1] ? PI_Q : '0;
				end else if (ex == '0) begin
					h_q <= ey[DIFF_W-1] ? -HALF_PI_Q : HALF_PI_Q;
				end
				if (ex[DIFF_W-1]) begin
					x_q <= -VEC_W'(ex);
					y_q <= -VEC_W'(ey);
					z_q <= ey[DIFF_W-1] ? -PI_Z : PI_Z;
				end else begin
					x_q <= VEC_W'(ex);
					y_q <= VEC_W'(ey);
					z_q <= '0;
				end
			end
			ST_NORM: begin
				if (norm_by8) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (norm_by1) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			ST_CORDIC: begin
				// rotate toward the x axis
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + z_add;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - z_add;
				end
			end
			ST_ROUND: begin
				h_q <= h_rnd;
			end
			ST_GATE: begin
				if (out_free) begin
					out_x_q       <= mx_q;
					out_y_q       <= my_q;
					out_heading_q <= held ? last_heading_q : h_q;
					out_held_q    <= held;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign map_x        = out_x_q;
	assign map_y        = out_y_q;
	assign heading      = out_heading_q;
	assign heading_held = out_held_q;

	// a request closes the request channel for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// offered heading lies in (-pi, pi]
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heading > -PI_Q) && (heading <= PI_Q))
		else $error("heading out of range");

	// a held result repeats the kept heading
	a_held_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && heading_held |-> heading == last_heading_q)
		else $error("held heading differs from kept heading");

	// CORDIC leaves only after its last iteration
	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORDIC && iter_q != ITER_W'(CORDIC_STEPS - 1) |=> state_q == ST_CORDIC)
		else $error("CORDIC left early");

endmodule
